@@ rtl/dpq_pkg.sv @@
// dpq_pkg: shared types and constants for the deadline priority queue
// no dependencies; imported by dpq_cell and deadline_priority_queue
package dpq_pkg;

	localparam int DEPTH_DEF       = 16;
	localparam int TIME_BITS_DEF   = 48;
	localparam int HANDLE_BITS_DEF = 16;

	// operation codes carried on mode
	typedef enum logic [1:0] {
		MODE_PUSH  = 2'd0,
		MODE_POP   = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_NONE = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// per-cycle shift control broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

endpackage

@@ rtl/dpq_cell.sv @@
// dpq_cell: one slot of the sorted queue, a deadline and a handle
// depends on dpq_pkg (cell_ctl_t)
module dpq_cell import dpq_pkg::*; #(
	parameter int TIME_BITS   = TIME_BITS_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic                   clk,
	input  cell_ctl_t              ctl,
	input  logic                   occupied,
	input  logic [TIME_BITS-1:0]   new_deadline,
	input  logic [HANDLE_BITS-1:0] new_handle,
	input  logic                   left_after,
	input  logic [TIME_BITS-1:0]   left_deadline,
	input  logic [HANDLE_BITS-1:0] left_handle,
	input  logic [TIME_BITS-1:0]   right_deadline,
	input  logic [HANDLE_BITS-1:0] right_handle,
	output logic                   after,
	output logic [TIME_BITS-1:0]   deadline_q,
	output logic [HANDLE_BITS-1:0] handle_q
);

	// new entry lands at or before this slot
	assign after = !occupied || (deadline_q > new_deadline);

	always_ff @(posedge clk) begin
		if (ctl.push && after) begin
			if (left_after) begin
				deadline_q <= left_deadline;
				handle_q   <= left_handle;
			end else begin
				deadline_q <= new_deadline;
				handle_q   <= new_handle;
			end
		end else if (ctl.pop) begin
			deadline_q <= right_deadline;
			handle_q   <= right_handle;
		end
	end

endmodule

@@ rtl/deadline_priority_queue.sv @@
// deadline_priority_queue: top level, a row of dpq_cell slots kept sorted by deadline
// depends on dpq_pkg and dpq_cell
//
// the queue holds up to DEPTH pending sends, each a deadline and a handle, in a
// row of cells sorted by deadline, earliest in cell 0; equal deadlines keep push
// order. one word is taken per cycle (busy stays low) and its result appears on
// the result ports in the following cycle, marked by done for one cycle; the
// receiver cannot stall, so every result must be taken as it appears. all cells
// compare the pushed deadline in parallel and shift by one place together. a pop
// only removes the head cell when its deadline is not later than current_time.
// earliest_deadline and occupancy are read straight from the cell row and counter
// during the done cycle.
module deadline_priority_queue import dpq_pkg::*; #(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF,
	localparam int CNT_BITS   = $clog2(DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             mode,
	input  logic [TIME_BITS-1:0]   deadline,
	input  logic [HANDLE_BITS-1:0] handle,
	input  logic [TIME_BITS-1:0]   current_time,
	output logic                   done,
	output logic [1:0]             status,
	output logic [HANDLE_BITS-1:0] popped_handle,
	output logic [TIME_BITS-1:0]   earliest_deadline,
	output logic [CNT_BITS-1:0]    occupancy
);

	localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

	mode_t                  mode_c;
	logic                   accept;
	logic                   is_full;
	logic                   is_empty;
	logic                   pop_ok;
	cell_ctl_t              ctl;
	logic [CNT_BITS-1:0]    count_q;
	logic                   done_q;
	status_t                status_q;
	status_t                status_d;
	logic [HANDLE_BITS-1:0] popped_q;
	logic [HANDLE_BITS-1:0] popped_d;

	logic [TIME_BITS-1:0]   cell_d [DEPTH];
	logic [HANDLE_BITS-1:0] cell_h [DEPTH];
	logic                   cell_after [DEPTH];

	// never busy, so a new word is taken while the last one completes
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign mode_c = mode_t'(mode);

	assign is_full  = (count_q == FULL_CNT);
	assign is_empty = (count_q == '0);
	// head is due when its deadline has been reached
	assign pop_ok   = !is_empty && (cell_d[0] <= current_time);

	always_comb begin
		ctl      = '0;
		status_d = ST_NONE;
		popped_d = '0;
		case (mode_c)
			MODE_PUSH: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					ctl.push = accept;
					status_d = ST_DONE;
				end
			end
			MODE_POP: begin
				if (pop_ok) begin
					ctl.pop  = accept;
					status_d = ST_DONE;
					popped_d = cell_h[0];
				end
			end
			MODE_CLEAR: begin
				status_d = ST_DONE;
			end
			default: begin
				status_d = ST_NONE;
			end
		endcase
	end

	// the cell row: each cell looks at its left and right neighbour
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                   occ;
		logic                   l_after;
		logic [TIME_BITS-1:0]   l_d;
		logic [HANDLE_BITS-1:0] l_h;
		logic [TIME_BITS-1:0]   r_d;
		logic [HANDLE_BITS-1:0] r_h;

		assign occ = (count_q > CNT_BITS'(i));

		if (i == 0) begin : g_head
			assign l_after = 1'b0;
			assign l_d     = deadline;
			assign l_h     = handle;
		end else begin : g_body
			assign l_after = cell_after[i-1];
			assign l_d     = cell_d[i-1];
			assign l_h     = cell_h[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_d = cell_d[i];
			assign r_h = cell_h[i];
		end else begin : g_inner
			assign r_d = cell_d[i+1];
			assign r_h = cell_h[i+1];
		end

		dpq_cell #(
			.TIME_BITS   (TIME_BITS),
			.HANDLE_BITS (HANDLE_BITS)
		) u_cell (
			.clk            (clk),
			.ctl            (ctl),
			.occupied       (occ),
			.new_deadline   (deadline),
			.new_handle     (handle),
			.left_after     (l_after),
			.left_deadline  (l_d),
			.left_handle    (l_h),
			.right_deadline (r_d),
			.right_handle   (r_h),
			.after          (cell_after[i]),
			.deadline_q     (cell_d[i]),
			.handle_q       (cell_h[i])
		);
	end

	// entry counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && (mode_c == MODE_CLEAR)) begin
			count_q <= '0;
		end else if (ctl.push) begin
			count_q <= count_q + 1'b1;
		end else if (ctl.pop) begin
			count_q <= count_q - 1'b1;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			popped_q <= popped_d;
		end
	end

	assign done              = done_q;
	assign status            = status_q;
	assign popped_handle     = popped_q;
	assign occupancy         = count_q;
	// head cell, or all ones when nothing is held
	assign earliest_deadline = is_empty ? {TIME_BITS{1'b1}} : cell_d[0];

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("occupancy beyond depth");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (mode_c == MODE_CLEAR) |=> is_empty && (earliest_deadline == {TIME_BITS{1'b1}}))
		else $error("clear left entries");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (mode_c == MODE_POP) && pop_ok |=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not remove one entry");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (mode_c == MODE_PUSH) && is_full |=> (status == ST_FULL) && (count_q == FULL_CNT))
		else $error("push into full queue not dropped");

	a_push_no_shift_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.push && ctl.pop))
		else $error("push and pop shift together");
`endif

endmodule
